### hdl/encl_pkg.sv
// Package for the envelope nesting chain length block.
// Holds the beat structs, sizing constants and the sort-key function.
// No dependencies.
package encl_pkg;

    localparam int unsigned MaxPairsDefault = 1024;
    localparam int unsigned LenWidth        = 11;

    typedef struct packed {
        logic signed [31:0] width;
        logic signed [31:0] height;
        logic               last_pair;
    } t_in_beat;

    typedef struct packed {
        logic [LenWidth-1:0] chain_length;
        logic                overflow;
    } t_out_beat;

    // True when pair a sorts before pair b: width ascending, then height descending.
    function automatic logic goes_before(input logic signed [31:0] aw,
                                         input logic signed [31:0] ah,
                                         input logic signed [31:0] bw,
                                         input logic signed [31:0] bh);
        logic res;
        if (aw != bw) begin
            res = (aw < bw);
        end else begin
            res = (ah > bh);
        end
        return res;
    endfunction

endpackage

### hdl/envelope_nesting_chain_length.sv
// Top level of the envelope nesting chain length block.
// Stores pairs, insertion-sorts them in memory, then runs a patience search.
// Depends on encl_pkg.
//
// Channel | Direction | Payload
// in      | input     | encl_pkg::t_in_beat  (i_in_valid / o_in_ready)
// out     | output    | encl_pkg::t_out_beat (o_out_valid / i_out_ready)
//
// Pairs are loaded at one beat per cycle into the pair memory while no result
// is waiting on the output. After the last beat, an insertion sort shifts each
// element past the stored ones that it sorts before, then the patience pass runs
// a binary search of the tails memory for each pair.
// Both passes read one pair memory through a single read port; the patience pass also uses one tails memory.
// Reset is synchronous; no memory is cleared. Input stalls while a set is processed.
module envelope_nesting_chain_length #(
    parameter int unsigned MAX_PAIRS = encl_pkg::MaxPairsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  encl_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output encl_pkg::t_out_beat o_out_data
);
    import encl_pkg::*;

    localparam int unsigned AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int unsigned CW = $clog2(MAX_PAIRS + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_SI_RD, S_SI_WT, S_SJ_RD, S_SJ_WT, S_SJ_CMP, S_SPUT,
        S_PI_RD, S_PI_WT, S_PB_RD, S_PB_WT, S_PB_CMP, S_DONE
    } t_state;

    logic [63:0] r_pmem [MAX_PAIRS];
    logic [31:0] r_tmem [MAX_PAIRS];

    t_state      r_state;
    logic [CW-1:0] r_count, r_len, r_i, r_j, r_lo, r_hi;
    logic        r_ovf;
    logic [63:0] r_cur, r_prd;
    logic [31:0] r_trd;
    logic        r_out_valid;
    t_out_beat   r_out;

    logic        pw_en;
    logic [AW-1:0] pw_addr, pr_addr, tr_addr, tw_addr;
    logic [63:0] pw_data;
    logic        tw_en;
    logic [31:0] tw_data;
    logic [CW-1:0] mid;

    assign o_in_ready  = (r_state == S_LOAD) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign mid = r_lo + ((r_hi - r_lo) >> 1);

    always_ff @(posedge i_clk) begin
        if (pw_en) begin
            r_pmem[pw_addr] <= pw_data;
        end
        r_prd <= r_pmem[pr_addr];
        if (tw_en) begin
            r_tmem[tw_addr] <= tw_data;
        end
        r_trd <= r_tmem[tr_addr];
    end

    always_comb begin
        pw_en   = 1'b0;
        pw_addr = r_count[AW-1:0];
        pw_data = {i_in_data.width, i_in_data.height};
        pr_addr = r_i[AW-1:0];
        tw_en   = 1'b0;
        tw_addr = r_lo[AW-1:0];
        tw_data = r_cur[31:0];
        tr_addr = mid[AW-1:0];
        unique case (r_state)
            S_LOAD: begin
                pw_en = i_in_valid && o_in_ready && (r_count < CW'(MAX_PAIRS));
            end
            S_SJ_RD: pr_addr = AW'(r_j - 1'b1);
            S_SJ_CMP: begin
                pw_addr = r_j[AW-1:0];
                if (r_j != '0 && goes_before(r_cur[63:32], r_cur[31:0],
                                             r_prd[63:32], r_prd[31:0])) begin
                    pw_en   = 1'b1;
                    pw_data = r_prd;
                end
            end
            S_SPUT: begin
                pw_en   = 1'b1;
                pw_addr = r_j[AW-1:0];
                pw_data = r_cur;
            end
            S_PB_RD: tr_addr = mid[AW-1:0];
            S_PB_CMP: begin
                tw_en = (r_lo == r_hi);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (i_in_valid && o_in_ready) begin
                        if (r_count < CW'(MAX_PAIRS)) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in_data.last_pair) begin
                            r_i     <= CW'(1);
                            r_state <= S_SI_RD;
                        end
                    end
                end
                S_SI_RD: begin
                    if (r_i >= r_count) begin
                        r_i     <= '0;
                        r_len   <= '0;
                        r_state <= S_PI_RD;
                    end else begin
                        r_state <= S_SI_WT;
                    end
                end
                S_SI_WT: begin
                    r_state <= S_SJ_WT;
                    r_j     <= r_i;
                end
                S_SJ_WT: begin
                    r_cur   <= r_prd;
                    r_state <= S_SJ_RD;
                end
                S_SJ_RD: r_state <= S_SJ_CMP;
                S_SJ_CMP: begin
                    if (r_j != '0 && goes_before(r_cur[63:32], r_cur[31:0],
                                                 r_prd[63:32], r_prd[31:0])) begin
                        r_j     <= r_j - 1'b1;
                        r_state <= S_SJ_RD;
                    end else begin
                        r_state <= S_SPUT;
                    end
                end
                S_SPUT: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= S_SI_RD;
                end
                S_PI_RD: begin
                    if (r_i >= r_count) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_PI_WT;
                    end
                end
                S_PI_WT: begin
                    r_cur <= r_prd;
                    r_lo  <= '0;
                    r_hi  <= r_len;
                    r_state <= S_PB_RD;
                end
                S_PB_RD: begin
                    if (r_lo == r_hi) begin
                        r_state <= S_PB_CMP;
                    end else begin
                        r_state <= S_PB_WT;
                    end
                end
                S_PB_WT: begin
                    if ($signed(r_trd) < $signed(r_cur[31:0])) begin
                        r_lo <= mid + 1'b1;
                    end else begin
                        r_hi <= mid;
                    end
                    r_state <= S_PB_RD;
                end
                S_PB_CMP: begin
                    if (r_lo == r_len) begin
                        r_len <= r_len + 1'b1;
                    end
                    r_i     <= r_i + 1'b1;
                    r_state <= S_PI_RD;
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        r_out_valid        <= 1'b1;
                        r_out.chain_length <= LenWidth'(r_len);
                        r_out.overflow     <= r_ovf;
                        r_count <= '0;
                        r_len   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PAIRS)) else $error("pair count beyond capacity");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= r_count) else $error("tails length beyond pair count");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_LOAD) else $error("ready outside load");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out)) else $error("result changed");
`endif

endmodule
